### design/nonlinear_ladder_lowpass_assert.svh
// Assertion macros for the nonlinear ladder lowpass RTL.
`ifndef NONLINEAR_LADDER_LOWPASS_ASSERT_SVH
`define NONLINEAR_LADDER_LOWPASS_ASSERT_SVH
`ifndef SYNTHESIS
`define NLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NLL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NLL_ASSERT(lbl, prop, msg)
`define NLL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### design/nll_pkg.sv
// Package: widths, constants, types and sequencer states of the ladder lowpass.
package nll_pkg;

  localparam int STAGES    = 4;
  localparam int SIDX_W    = $clog2(STAGES);
  localparam int SAMPLE_W  = 24;
  localparam int CUTOFF_W  = 15;
  localparam int RES_W     = 16;
  localparam int DRIVE_W   = 16;
  localparam int RATE_W    = 18;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  localparam int VOLT_W  = 32;
  localparam int SLOPE_W = 48;
  localparam int TANH_W  = 18;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIVD_W = 64;
  localparam int DIVS_W = 33;
  localparam int QUO_W  = 32;

  localparam int DIV_LONG_BITS  = 31;
  localparam int DIV_SHORT_BITS = 17;
  localparam int DIV_CNT_W      = $clog2(DIV_LONG_BITS + 1);

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 15'd1000;
  localparam logic [RES_W-1:0]    RES_RST    = 16'd0;
  localparam logic [DRIVE_W-1:0]  DRIVE_RST  = 16'd4096;
  localparam logic [RATE_W-1:0]   RATE_RST   = 18'd44100;

  localparam logic [RATE_W-1:0] OVERSAMPLE_RATE = 18'd96000;
  localparam logic signed [MUL_W-1:0] PI_Q30        = 33'sd3373259426;
  localparam logic signed [MUL_W-1:0] TWO_PI_VT_Q30 = 33'sd2104913883;
  localparam int ONE_Q30        = 1073741824;
  localparam int INV_TWO_VT_Q16 = 105026;
  localparam int TANH_K27       = 27 * 65536;
  localparam int V_ARG_LIMIT    = 33554432;
  localparam int TANH_ARG_LIMIT = 3 * 65536;
  localparam longint VOLT_MAX   = 64'sd2147483647;
  localparam longint VOLT_MIN   = -64'sd2147483648;
  localparam int SAMPLE_MAX     = 8388607;
  localparam int SAMPLE_MIN     = -8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF,
    REG_RESONANCE,
    REG_DRIVE,
    REG_RATE
  } cfg_idx_t;

  typedef struct packed {
    logic [CUTOFF_W-1:0] cutoff;
    logic [RES_W-1:0]    resonance;
    logic [DRIVE_W-1:0]  drive;
    logic [RATE_W-1:0]   rate;
  } cfg_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0]  volt;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [TANH_W-1:0]  th;
  } state_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [SIDX_W-1:0] rd_addr;
    logic              we;
    logic [SIDX_W-1:0] wr_addr;
    state_word_t       wdata;
  } mem_req_t;

  typedef struct packed {
    logic                     start;
    logic                     long_mode;
    logic signed [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_D_PI,
    S_D_XQ_GO,
    S_D_XQ_WAIT,
    S_D_RAT_GO,
    S_D_RAT_WAIT,
    S_D_BASE_MUL,
    S_D_BASE_GO,
    S_D_BASE_WAIT,
    S_D_GAIN_MUL,
    S_D_GAIN,
    S_IDLE,
    S_IN_DRIVE,
    S_IN_FEED,
    S_IN_SUM,
    S_TH_MUL,
    S_TH_ARG,
    S_TH_SQ,
    S_TH_NUM,
    S_TH_NMUL,
    S_TH_DIV,
    S_TH_WAIT,
    S_ST_READ,
    S_ST_LOAD,
    S_ST_MUL,
    S_ST_INT,
    S_ST_WB,
    S_DONE
  } eng_state_t;

endpackage

### design/nll_state_mem.sv
// Stage state memory: voltage, slope and saturated output per stage, registered read.
module nll_state_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nll_pkg::mem_req_t    req,
  output nll_pkg::state_word_t rdata
);
  import nll_pkg::*;

  state_word_t       mem [STAGES];
  logic [STAGES-1:0] vld_r;
  state_word_t       rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

### design/nll_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
module nll_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nll_pkg::div_req_t req,
  output nll_pkg::div_rsp_t rsp
);
  import nll_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0]    dsr_r, dsr_nxt;
  logic [QUO_W-1:0]     q_r, q_nxt;
  logic                 neg_r, neg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[DIVD_W-1];
      rem_nxt  = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend) : DIVD_W'(req.dividend);
      q_nxt    = '0;
      if (req.long_mode) begin
        dsr_nxt = DIVD_W'(req.divisor) << (DIV_LONG_BITS - 1);
        cnt_nxt = DIV_CNT_W'(DIV_LONG_BITS);
      end else begin
        dsr_nxt = DIVD_W'(req.divisor) << (DIV_SHORT_BITS - 1);
        cnt_nxt = DIV_CNT_W'(DIV_SHORT_BITS);
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (rem_r >= dsr_r) begin
          rem_nxt = rem_r - dsr_r;
          q_nxt   = {q_r[QUO_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[QUO_W-2:0], 1'b0};
        end
        dsr_nxt = dsr_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

### design/nll_engine.sv
// Sequencer and shared multiplier: gain setup, drive/feedback, tanh and stage updates.
`include "nonlinear_ladder_lowpass_assert.svh"
module nll_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nll_pkg::cfg_t                       cfg,
  input  logic                                cfg_wr,
  input  logic                                in_valid,
  input  logic signed [nll_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                in_ready,
  input  logic                                res_ready,
  output logic                                res_push,
  output logic signed [nll_pkg::SAMPLE_W-1:0] res_sample,
  output nll_pkg::mem_req_t                   mem_req,
  input  nll_pkg::state_word_t                mem_rdata,
  output nll_pkg::div_req_t                   div_req,
  input  nll_pkg::div_rsp_t                   div_rsp
);
  import nll_pkg::*;

  localparam int VIN_W  = 35;
  localparam int VCL_W  = 27;
  localparam int SH_W   = 22;
  localparam int A_W    = 19;
  localparam int A2_W   = 20;
  localparam int DIFF_W = TANH_W + 1;
  localparam int INC_W  = 28;
  localparam int SUM_W  = 50;

  eng_state_t state_r, state_nxt;
  logic [SIDX_W-1:0] idx_r, idx_nxt;
  logic ret_stage_r, ret_stage_nxt;

  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [VOLT_W-1:0]   v3_r, v3_nxt;
  logic signed [VIN_W-1:0]    t_r, t_nxt;
  logic signed [VIN_W-1:0]    vin_r, vin_nxt;
  logic signed [A_W-1:0]      a_r, a_nxt;
  logic [A2_W-1:0]            a2_r, a2_nxt;
  logic signed [PROD_W-1:0]   p_r;
  logic signed [TANH_W-1:0]   tin_r, tin_nxt;
  logic signed [TANH_W-1:0]   prev_r, prev_nxt;
  logic signed [TANH_W-1:0]   th_r, th_nxt;
  logic signed [VOLT_W-1:0]   cur_v_r, cur_v_nxt;
  logic signed [SLOPE_W-1:0]  cur_slope_r, cur_slope_nxt;
  logic signed [TANH_W-1:0]   cur_th_r, cur_th_nxt;
  logic signed [INC_W-1:0]    inc_r, inc_nxt;
  logic signed [VOLT_W-1:0]   new_v_r, new_v_nxt;
  logic signed [QUO_W-1:0]    cg_r, cg_nxt;
  logic signed [QUO_W-1:0]    xq_r, xq_nxt;
  logic signed [QUO_W-1:0]    ratio_r, ratio_nxt;
  logic signed [QUO_W-1:0]    base_r, base_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [RATE_W-1:0]        rate;
  logic signed [VCL_W-1:0]  v_cl;
  logic signed [SH_W-1:0]   sh;
  logic signed [DIFF_W-1:0] diff;
  logic signed [INC_W-1:0]  inc_w;
  logic signed [SUM_W-1:0]  vsum;
  logic signed [MUL_W-1:0]  one_m_xq;
  logic signed [MUL_W-1:0]  neg_v;

  assign prod = mul_a * mul_b;
  assign rate = (cfg.rate > OVERSAMPLE_RATE) ? cfg.rate : OVERSAMPLE_RATE;
  assign sh   = p_r[SH_W+22:23];
  assign inc_w = p_r[INC_W+22:23];
  assign one_m_xq = MUL_W'(ONE_Q30) - MUL_W'(xq_r);
  assign neg_v = -MUL_W'(new_v_r);
  assign vsum = SUM_W'(cur_v_r) + SUM_W'(inc_w) + SUM_W'(cur_slope_r);

  always_comb begin
    if (vin_r > V_ARG_LIMIT) begin
      v_cl = VCL_W'(V_ARG_LIMIT);
    end else if (vin_r < -V_ARG_LIMIT) begin
      v_cl = VCL_W'(-V_ARG_LIMIT);
    end else begin
      v_cl = VCL_W'(vin_r);
    end
    if (idx_r == '0) begin
      diff = -(DIFF_W'(tin_r) + DIFF_W'(cur_th_r));
    end else begin
      diff = DIFF_W'(prev_r) - DIFF_W'(cur_th_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_D_PI;
      idx_r       <= '0;
      ret_stage_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ret_stage_r <= ret_stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    v3_r        <= v3_nxt;
    t_r         <= t_nxt;
    vin_r       <= vin_nxt;
    a_r         <= a_nxt;
    a2_r        <= a2_nxt;
    p_r         <= prod;
    tin_r       <= tin_nxt;
    prev_r      <= prev_nxt;
    th_r        <= th_nxt;
    cur_v_r     <= cur_v_nxt;
    cur_slope_r <= cur_slope_nxt;
    cur_th_r    <= cur_th_nxt;
    inc_r       <= inc_nxt;
    new_v_r     <= new_v_nxt;
    cg_r        <= cg_nxt;
    xq_r        <= xq_nxt;
    ratio_r     <= ratio_nxt;
    base_r      <= base_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ret_stage_nxt = ret_stage_r;
    x_nxt         = x_r;
    v3_nxt        = v3_r;
    t_nxt         = t_r;
    vin_nxt       = vin_r;
    a_nxt         = a_r;
    a2_nxt        = a2_r;
    tin_nxt       = tin_r;
    prev_nxt      = prev_r;
    th_nxt        = th_r;
    cur_v_nxt     = cur_v_r;
    cur_slope_nxt = cur_slope_r;
    cur_th_nxt    = cur_th_r;
    inc_nxt       = inc_r;
    new_v_nxt     = new_v_r;
    cg_nxt        = cg_r;
    xq_nxt        = xq_r;
    ratio_nxt     = ratio_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    mul_a         = '0;
    mul_b         = '0;
    in_ready      = 1'b0;
    res_push      = 1'b0;
    mem_req       = '0;
    div_req       = '0;

    case (state_r)
      S_D_PI: begin
        mul_a     = PI_Q30;
        mul_b     = MUL_W'(cfg.cutoff);
        state_nxt = S_D_XQ_GO;
      end
      S_D_XQ_GO: begin
        div_req.start     = 1'b1;
        div_req.long_mode = 1'b1;
        div_req.dividend  = p_r[DIVD_W-1:0];
        div_req.divisor   = DIVS_W'(rate);
        state_nxt         = S_D_XQ_WAIT;
      end
      S_D_XQ_WAIT: begin
        if (div_rsp.done) begin
          xq_nxt    = div_rsp.quot;
          state_nxt = S_D_RAT_GO;
        end
      end
      S_D_RAT_GO: begin
        div_req.start     = 1'b1;
        div_req.long_mode = 1'b1;
        div_req.dividend  = DIVD_W'(one_m_xq) <<< 30;
        div_req.divisor   = DIVS_W'(ONE_Q30) + DIVS_W'(xq_r);
        state_nxt         = S_D_RAT_WAIT;
      end
      S_D_RAT_WAIT: begin
        if (div_rsp.done) begin
          ratio_nxt = div_rsp.quot;
          state_nxt = S_D_BASE_MUL;
        end
      end
      S_D_BASE_MUL: begin
        mul_a     = TWO_PI_VT_Q30;
        mul_b     = MUL_W'(cfg.cutoff);
        state_nxt = S_D_BASE_GO;
      end
      S_D_BASE_GO: begin
        div_req.start     = 1'b1;
        div_req.long_mode = 1'b1;
        div_req.dividend  = p_r[DIVD_W-1:0];
        div_req.divisor   = DIVS_W'(rate);
        state_nxt         = S_D_BASE_WAIT;
      end
      S_D_BASE_WAIT: begin
        if (div_rsp.done) begin
          base_nxt  = div_rsp.quot;
          state_nxt = S_D_GAIN_MUL;
        end
      end
      S_D_GAIN_MUL: begin
        mul_a     = MUL_W'(base_r);
        mul_b     = MUL_W'(ratio_r);
        state_nxt = S_D_GAIN;
      end
      S_D_GAIN: begin
        cg_nxt    = p_r[QUO_W+29:30];
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt           = in_sample;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = SIDX_W'(STAGES - 1);
          state_nxt       = S_IN_DRIVE;
        end
      end
      S_IN_DRIVE: begin
        v3_nxt    = mem_rdata.volt;
        mul_a     = MUL_W'(x_r);
        mul_b     = MUL_W'(cfg.drive);
        state_nxt = S_IN_FEED;
      end
      S_IN_FEED: begin
        t_nxt     = p_r[VIN_W+11:12];
        mul_a     = MUL_W'(v3_r);
        mul_b     = MUL_W'(cfg.resonance);
        state_nxt = S_IN_SUM;
      end
      S_IN_SUM: begin
        vin_nxt       = t_r + p_r[VIN_W+13:14];
        ret_stage_nxt = 1'b0;
        state_nxt     = S_TH_MUL;
      end
      S_TH_MUL: begin
        mul_a     = MUL_W'(v_cl);
        mul_b     = MUL_W'(INV_TWO_VT_Q16);
        state_nxt = S_TH_ARG;
      end
      S_TH_ARG: begin
        if (sh > TANH_ARG_LIMIT) begin
          a_nxt = A_W'(TANH_ARG_LIMIT);
        end else if (sh < -TANH_ARG_LIMIT) begin
          a_nxt = A_W'(-TANH_ARG_LIMIT);
        end else begin
          a_nxt = A_W'(sh);
        end
        state_nxt = S_TH_SQ;
      end
      S_TH_SQ: begin
        mul_a     = MUL_W'(a_r);
        mul_b     = MUL_W'(a_r);
        state_nxt = S_TH_NUM;
      end
      S_TH_NUM: begin
        a2_nxt    = p_r[A2_W+15:16];
        state_nxt = S_TH_NMUL;
      end
      S_TH_NMUL: begin
        mul_a     = MUL_W'(a_r);
        mul_b     = MUL_W'(a2_r) + MUL_W'(TANH_K27);
        state_nxt = S_TH_DIV;
      end
      S_TH_DIV: begin
        div_req.start     = 1'b1;
        div_req.long_mode = 1'b0;
        div_req.dividend  = p_r[DIVD_W-1:0];
        div_req.divisor   = DIVS_W'(a2_r) + (DIVS_W'(a2_r) << 3) + DIVS_W'(TANH_K27);
        state_nxt         = S_TH_WAIT;
      end
      S_TH_WAIT: begin
        if (div_rsp.done) begin
          th_nxt = div_rsp.quot[TANH_W-1:0];
          if (ret_stage_r) begin
            state_nxt = S_ST_WB;
          end else begin
            tin_nxt   = div_rsp.quot[TANH_W-1:0];
            idx_nxt   = '0;
            state_nxt = S_ST_READ;
          end
        end
      end
      S_ST_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r;
        state_nxt       = S_ST_LOAD;
      end
      S_ST_LOAD: begin
        cur_v_nxt     = mem_rdata.volt;
        cur_slope_nxt = mem_rdata.slope;
        cur_th_nxt    = mem_rdata.th;
        state_nxt     = S_ST_MUL;
      end
      S_ST_MUL: begin
        mul_a     = MUL_W'(cg_r);
        mul_b     = MUL_W'(diff);
        state_nxt = S_ST_INT;
      end
      S_ST_INT: begin
        inc_nxt = inc_w;
        if (vsum > VOLT_MAX) begin
          new_v_nxt = VOLT_W'(VOLT_MAX);
          vin_nxt   = VIN_W'(VOLT_MAX);
        end else if (vsum < VOLT_MIN) begin
          new_v_nxt = VOLT_W'(VOLT_MIN);
          vin_nxt   = VIN_W'(VOLT_MIN);
        end else begin
          new_v_nxt = VOLT_W'(vsum);
          vin_nxt   = VIN_W'(vsum);
        end
        ret_stage_nxt = 1'b1;
        state_nxt     = S_TH_MUL;
      end
      S_ST_WB: begin
        mem_req.we          = 1'b1;
        mem_req.wr_addr     = idx_r;
        mem_req.wdata.volt  = new_v_r;
        mem_req.wdata.slope = SLOPE_W'(inc_r);
        mem_req.wdata.th    = th_r;
        prev_nxt            = th_r;
        if (idx_r == SIDX_W'(STAGES - 1)) begin
          if (neg_v > SAMPLE_MAX) begin
            res_nxt = SAMPLE_W'(SAMPLE_MAX);
          end else if (neg_v < SAMPLE_MIN) begin
            res_nxt = SAMPLE_W'(SAMPLE_MIN);
          end else begin
            res_nxt = SAMPLE_W'(neg_v);
          end
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ST_READ;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_D_PI;
      end
    endcase

    if (cfg_wr) begin
      state_nxt = S_D_PI;
    end
  end

  assign res_sample = res_r;

  `NLL_ASSERT(a_idle_div_quiet, (state_r == S_IDLE) |-> !div_rsp.busy, "divider busy while idle")
  `NLL_ASSERT_NEXT(a_div_no_early_done, div_req.start, !div_rsp.done, "divider done too early")

endmodule

### design/nonlinear_ladder_lowpass.sv
// Top level: four-stage nonlinear ladder lowpass with registers and result register.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+--------------------
//   input   | in_sample[23:0] signed Q1.23   | in_valid / in_ready
//   result  | out_sample[23:0] signed Q1.23  | out_valid / out_ready
//   config  | cfg_index[1:0], cfg_wdata[17:0]| cfg_we, no wait
//
// Each request takes five tanh evaluations, each bound by the
// 17-step shared divider, plus the stage memory read-modify-write per stage.
// After reset and after every register write the gain setup runs
// (three 31-step divides); in_ready stays low meanwhile.
// A new request is taken while the previous result waits in the output register.
`include "nonlinear_ladder_lowpass_assert.svh"
module nonlinear_ladder_lowpass (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [nll_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [nll_pkg::SAMPLE_W-1:0]  out_sample,
  input  logic                                 cfg_we,
  input  logic [nll_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nll_pkg::CFG_W-1:0]            cfg_wdata
);
  import nll_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic res_ready, res_push;
  logic signed [SAMPLE_W-1:0] res_sample;
  mem_req_t    mem_req;
  state_word_t mem_rdata;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff    <= CUTOFF_RST;
      cfg_r.resonance <= RES_RST;
      cfg_r.drive     <= DRIVE_RST;
      cfg_r.rate      <= RATE_RST;
      out_valid_r     <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_CUTOFF:    cfg_nxt.cutoff    = cfg_wdata[CUTOFF_W-1:0];
        REG_RESONANCE: cfg_nxt.resonance = cfg_wdata[RES_W-1:0];
        REG_DRIVE:     cfg_nxt.drive     = cfg_wdata[DRIVE_W-1:0];
        REG_RATE:      cfg_nxt.rate      = cfg_wdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (res_push) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res_sample;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  nll_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  nll_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nll_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_wr     (cfg_we),
    .in_valid   (in_valid),
    .in_sample  (in_sample),
    .in_ready   (in_ready),
    .res_ready  (res_ready),
    .res_push   (res_push),
    .res_sample (res_sample),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

  `NLL_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

### verif/nll_ladder_checker.sv
// Checker for the ladder lowpass: predicts each filtered sample and compares results.
`timescale 1ns / 100ps
module nll_ladder_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [nll_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [nll_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                cfg_we,
  input  logic [nll_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nll_pkg::CFG_W-1:0]           cfg_wdata,
  output int                                  errors,
  output int                                  pending
);
  import nll_pkg::*;

  longint cutoff, resonance, drive, rate;
  longint volt [STAGES];
  longint slope [STAGES];
  longint th [STAGES];
  longint gain;
  logic signed [SAMPLE_W-1:0] filtered_q [$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint tanh_sat(longint v_q23);
    longint v, a, a2, num, den;
    v   = clip(v_q23, -longint'(V_ARG_LIMIT), longint'(V_ARG_LIMIT));
    a   = clip((v * INV_TWO_VT_Q16) >>> 23, -longint'(TANH_ARG_LIMIT),
               longint'(TANH_ARG_LIMIT));
    a2  = (a * a) >>> 16;
    num = a * (longint'(TANH_K27) + a2);
    den = longint'(TANH_K27) + 9 * a2;
    return num / den;
  endfunction

  function automatic void update_gain();
    longint eff, xq, ratio, base;
    eff   = (rate > longint'(OVERSAMPLE_RATE)) ? rate : longint'(OVERSAMPLE_RATE);
    xq    = (longint'(PI_Q30) * cutoff) / eff;
    ratio = ((longint'(ONE_Q30) - xq) * longint'(ONE_Q30)) / (longint'(ONE_Q30) + xq);
    base  = (longint'(TWO_PI_VT_Q30) * cutoff) / eff;
    gain  = (base * ratio) >>> 30;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(longint x);
    longint t_in, diff, inc;
    t_in = tanh_sat(((x * drive) >>> 12) + ((volt[STAGES-1] * resonance) >>> 14));
    for (int i = 0; i < STAGES; i++) begin
      diff = (i == 0) ? -(t_in + th[0]) : th[i-1] - th[i];
      inc = (gain * diff) >>> 23;
      volt[i] = clip(volt[i] + inc + slope[i], VOLT_MIN, VOLT_MAX);
      slope[i] = inc;
      th[i] = tanh_sat(volt[i]);
    end
    return SAMPLE_W'(clip(-volt[STAGES-1], SAMPLE_MIN, SAMPLE_MAX));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cutoff = CUTOFF_RST;
      resonance = RES_RST;
      drive = DRIVE_RST;
      rate = RATE_RST;
      for (int i = 0; i < STAGES; i++) begin
        volt[i] = 0;
        slope[i] = 0;
        th[i] = 0;
      end
      update_gain();
      filtered_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_CUTOFF:    cutoff = cfg_wdata[CUTOFF_W-1:0];
          REG_RESONANCE: resonance = cfg_wdata[RES_W-1:0];
          REG_DRIVE:     drive = cfg_wdata[DRIVE_W-1:0];
          REG_RATE:      rate = cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
        update_gain();
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("out_sample: expected none, actual %0d", out_sample);
          errors <= errors + 1;
        end else begin
          logic signed [SAMPLE_W-1:0] want;
          want = filtered_q.pop_front();
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, actual %0d", want, out_sample);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        filtered_q.push_back(filter_sample(longint'(in_sample)));
    end
    pending <= filtered_q.size();
  end

endmodule

### verif/tb_nonlinear_ladder_lowpass.sv
// Testbench top: drives samples and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_nonlinear_ladder_lowpass;
  import nll_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic signed [SAMPLE_W-1:0] in_sample, out_sample;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int errors, pending;
  int send_idle, recv_idle;
  int quiet_cycles;

  nonlinear_ladder_lowpass u_top (.*);

  nll_ladder_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_nonlinear_ladder_lowpass: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] v);
    logic rdy;
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = v;
    do begin
      #1 rdy = in_ready;
      @(negedge clk);
    end while (!rdy);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic write_all(int cut, int res, int drv, int rt);
    write_reg(REG_CUTOFF, CFG_W'(cut));
    write_reg(REG_RESONANCE, CFG_W'(res));
    write_reg(REG_DRIVE, CFG_W'(drv));
    write_reg(REG_RATE, CFG_W'(rt));
  endtask

  function automatic logic [CFG_W-1:0] with_junk(int val, int width);
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    for (int b = 0; b < width; b++) w[b] = val[b];
    return w;
  endfunction

  task automatic random_config();
    write_reg(REG_CUTOFF, with_junk($urandom_range(20000, 20), CUTOFF_W));
    write_reg(REG_RESONANCE, with_junk($urandom_range(65535), RES_W));
    write_reg(REG_DRIVE, with_junk($urandom_range(65535), DRIVE_W));
    write_reg(REG_RATE, CFG_W'($urandom_range(192000, 8000)));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom_range(16383)) - SAMPLE_W'(8192);
      1: return ($urandom_range(1)) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CUTOFF;
    cfg_wdata = '0;
    send_idle = 7;
    recv_idle = 63;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset settings first, then hard drive into saturation
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(4194304));
    send_sample(SAMPLE_W'(-1));
    drain();
    write_all(20000, 65535, 65535, 192000);
    repeat (6) send_sample(SAMPLE_W'(SAMPLE_MIN));
    repeat (5) send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
    // zero cutoff holds the stages
    write_reg(REG_CUTOFF, CFG_W'(0));
    repeat (2) send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
    // zero rate, cutoff high enough that the prewarp term passes one, excess value bits set
    write_reg(REG_RATE, CFG_W'(0));
    write_reg(REG_CUTOFF, {CFG_W{1'b1}});
    write_reg(REG_RESONANCE, {CFG_W{1'b1}});
    write_reg(REG_DRIVE, {CFG_W{1'b1}});
    repeat (4) send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : ((ph == 1) ? 63 : 0);
      recv_idle = (ph == 0) ? 63 : ((ph == 1) ? 7 : 0);
      for (int seg = 0; seg < 3; seg++) begin
        if (seg == 0 && ph == 0)
          write_all(20000, 65535, 65535, 192000);
        else if (seg == 0 && ph == 1)
          write_all(20, 0, 0, 8000);
        else
          random_config();
        repeat (55) send_sample(pick_sample());
        drain();
      end
    end

    if (errors == 0)
      $display("tb_nonlinear_ladder_lowpass: done, clean");
    else
      $display("tb_nonlinear_ladder_lowpass: done, errors");
    $finish;
  end

endmodule

### nonlinear_ladder_lowpass.f
+incdir+design
design/nll_pkg.sv
design/nll_state_mem.sv
design/nll_div.sv
design/nll_engine.sv
design/nonlinear_ladder_lowpass.sv
verif/nll_ladder_checker.sv
verif/tb_nonlinear_ladder_lowpass.sv
